// ===== hdl/nrt_pkg.sv =====
// ----------------------------------------------------------------------------
// nrt_pkg
// Types and codes shared by the node registry table and its checker.
// ----------------------------------------------------------------------------
package nrt_pkg;

  typedef enum logic [2:0] {
    OP_ADD        = 3'd0,
    OP_FIND_LONG  = 3'd1,
    OP_FIND_SHORT = 3'd2,
    OP_REMOVE     = 3'd3,
    OP_SET_STATE  = 3'd4,
    OP_NTH        = 3'd5,
    OP_TICK       = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_UPDATED   = 3'd1,
    STS_FULL      = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_BAD_SLOT  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_SLOT
  } fsm_e;

  // lifecycle state given to a freshly added node
  localparam logic [2:0] NODE_STATE_NEW = 3'd0;

  typedef struct packed {
    op_e         op;
    logic [63:0] long_addr;
    logic [15:0] short_addr;
    logic [4:0]  slot_sel;
    logic [2:0]  new_state;
    logic [4:0]  nth_index;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [4:0]  slot_out;
    logic [63:0] found_long;
    logic [15:0] found_short;
    logic [2:0]  found_state;
    logic [31:0] joined_at;
    logic [31:0] seen_at;
    logic [5:0]  live_count;
  } rsp_t;

  // one table row as held in the entry memory
  typedef struct packed {
    logic [63:0] long_addr;
    logic [15:0] short_addr;
    logic [2:0]  state;
    logic [31:0] join_at;
    logic [31:0] seen_at;
  } entry_t;

endpackage

// ===== hdl/nrt_mem.sv =====
// ----------------------------------------------------------------------------
// nrt_mem
// Simple dual-port entry memory: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module nrt_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 147
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/node_registry_table.sv =====
// ----------------------------------------------------------------------------
// node_registry_table
// Table of network nodes keyed by long address, held in one entry memory
// and scanned slot by slot.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req_i and raise start; the command transfers at
//   the rising edge where start is high and busy is low.
//   Result channel: done_o is high for exactly one cycle with rsp_o; the
//   receiver cannot stall it and must take it in that cycle.
//   Result path, by command:
//     tick, unused op, set state on a bad slot : answered from idle
//     set state on a valid slot                : slot read, then written
//     find, remove, nth, present-address add   : scan stops at the hit slot
//     add of a new address, and any miss       : scan covers every slot
//   The scan issues one memory read per cycle; the entry memory's read
//   data is registered, so the compare trails the read by one slot. busy
//   drops in the result cycle, so a new command may transfer there (one
//   command in flight). Reset clears the valid marks, the live count and
//   the tick counter; the entry memory is not cleared, only valid rows are
//   ever reported.
// ----------------------------------------------------------------------------
module node_registry_table #(
  parameter int TABLE_SLOTS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  nrt_pkg::req_t req_i,
  output logic          done_o,
  output nrt_pkg::rsp_t rsp_o
);

  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(TABLE_SLOTS);
  localparam logic [IW-1:0] LAST_C  = IW'(TABLE_SLOTS - 1);

  nrt_pkg::fsm_e             state_q, state_d;
  nrt_pkg::req_t             req_q, req_d;
  logic [CW-1:0]             idx_q, idx_d;
  logic                      rd_pend_q, rd_pend_d;
  logic [IW-1:0]             rd_idx_q, rd_idx_d;
  logic [TABLE_SLOTS-1:0]    valid_q, valid_d;
  logic [CW-1:0]             total_q, total_d;
  logic [31:0]               now_q, now_d;
  logic                      free_hit_q, free_hit_d;
  logic [IW-1:0]             free_idx_q, free_idx_d;
  logic [CW-1:0]             nth_cnt_q, nth_cnt_d;
  nrt_pkg::rsp_t             rsp_q, rsp_d;
  logic                      done_q, done_d;

  logic                      mem_we;
  logic [IW-1:0]             mem_waddr;
  nrt_pkg::entry_t           mem_wdata;
  logic [IW-1:0]             mem_raddr;
  nrt_pkg::entry_t           rd_entry;

  logic                      scan_v;
  logic                      hit;
  logic                      free_ok;
  logic [IW-1:0]             free_slot;
  logic [IW-1:0]             sel_idx;
  logic                      sel_ok;
  nrt_pkg::entry_t           upd;

  function automatic nrt_pkg::rsp_t mk_rsp(nrt_pkg::status_e st, logic [IW-1:0] slot,
                                           nrt_pkg::entry_t e, logic [CW-1:0] live);
    nrt_pkg::rsp_t r;
    r.status      = st;
    r.slot_out    = 5'(slot);
    r.found_long  = e.long_addr;
    r.found_short = e.short_addr;
    r.found_state = e.state;
    r.joined_at   = e.join_at;
    r.seen_at     = e.seen_at;
    r.live_count  = 6'(live);
    return r;
  endfunction

  function automatic nrt_pkg::rsp_t mk_empty(nrt_pkg::status_e st, logic [CW-1:0] live);
    nrt_pkg::rsp_t r;
    r            = '0;
    r.status     = st;
    r.live_count = 6'(live);
    return r;
  endfunction

  nrt_mem #(
    .DEPTH (TABLE_SLOTS),
    .WIDTH ($bits(nrt_pkg::entry_t))
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rd_entry)
  );

  assign busy   = (state_q != nrt_pkg::FSM_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assign scan_v  = valid_q[rd_idx_q];
  assign sel_idx = IW'(req_i.slot_sel);
  assign sel_ok  = (32'(req_i.slot_sel) < TABLE_SLOTS) && valid_q[sel_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= nrt_pkg::FSM_IDLE;
      valid_q    <= '0;
      total_q    <= '0;
      now_q      <= '0;
      done_q     <= 1'b0;
      rd_pend_q  <= 1'b0;
      free_hit_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      total_q    <= total_d;
      now_q      <= now_d;
      done_q     <= done_d;
      rd_pend_q  <= rd_pend_d;
      free_hit_q <= free_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    idx_q      <= idx_d;
    rd_idx_q   <= rd_idx_d;
    free_idx_q <= free_idx_d;
    nth_cnt_q  <= nth_cnt_d;
    rsp_q      <= rsp_d;
  end

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    idx_d      = idx_q;
    rd_pend_d  = rd_pend_q;
    rd_idx_d   = rd_idx_q;
    valid_d    = valid_q;
    total_d    = total_q;
    now_d      = now_q;
    free_hit_d = free_hit_q;
    free_idx_d = free_idx_q;
    nth_cnt_d  = nth_cnt_q;
    rsp_d      = rsp_q;
    done_d     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = rd_idx_q;
    mem_wdata  = rd_entry;
    mem_raddr  = idx_q[IW-1:0];
    hit        = 1'b0;
    upd        = rd_entry;
    free_ok    = free_hit_q || !scan_v;
    free_slot  = free_hit_q ? free_idx_q : rd_idx_q;

    case (state_q)
      nrt_pkg::FSM_IDLE: begin
        if (start) begin
          req_d      = req_i;
          idx_d      = '0;
          rd_pend_d  = 1'b0;
          free_hit_d = 1'b0;
          nth_cnt_d  = '0;
          case (req_i.op)
            nrt_pkg::OP_ADD, nrt_pkg::OP_FIND_LONG, nrt_pkg::OP_FIND_SHORT,
            nrt_pkg::OP_REMOVE, nrt_pkg::OP_NTH: begin
              state_d = nrt_pkg::FSM_SCAN;
            end
            nrt_pkg::OP_SET_STATE: begin
              if (sel_ok) begin
                mem_raddr = sel_idx;
                rd_idx_d  = sel_idx;
                state_d   = nrt_pkg::FSM_SLOT;
              end else begin
                rsp_d  = mk_empty(nrt_pkg::STS_BAD_SLOT, total_q);
                done_d = 1'b1;
              end
            end
            nrt_pkg::OP_TICK: begin
              now_d  = now_q + 32'd1;
              rsp_d  = mk_empty(nrt_pkg::STS_OK, total_q);
              done_d = 1'b1;
            end
            default: begin
              rsp_d  = mk_empty(nrt_pkg::STS_OK, total_q);
              done_d = 1'b1;
            end
          endcase
        end
      end

      nrt_pkg::FSM_SCAN: begin
        // read issue runs one slot ahead of the compare
        if (idx_q < SLOTS_C) begin
          rd_pend_d = 1'b1;
          rd_idx_d  = idx_q[IW-1:0];
          idx_d     = idx_q + CW'(1);
        end else begin
          rd_pend_d = 1'b0;
        end

        if (rd_pend_q) begin
          case (req_q.op)
            nrt_pkg::OP_ADD, nrt_pkg::OP_FIND_LONG, nrt_pkg::OP_REMOVE:
              hit = scan_v && (rd_entry.long_addr == req_q.long_addr);
            nrt_pkg::OP_FIND_SHORT:
              hit = scan_v && (rd_entry.short_addr == req_q.short_addr);
            nrt_pkg::OP_NTH:
              hit = scan_v && (32'(nth_cnt_q) == 32'(req_q.nth_index));
            default:
              hit = 1'b0;
          endcase

          if (hit) begin
            state_d = nrt_pkg::FSM_IDLE;
            done_d  = 1'b1;
            case (req_q.op)
              nrt_pkg::OP_ADD: begin
                upd.short_addr = req_q.short_addr;
                upd.seen_at    = now_q;
                mem_we         = 1'b1;
                mem_wdata      = upd;
                rsp_d          = mk_rsp(nrt_pkg::STS_UPDATED, rd_idx_q, upd, total_q);
              end
              nrt_pkg::OP_REMOVE: begin
                valid_d[rd_idx_q] = 1'b0;
                if (total_q != '0) begin
                  total_d = total_q - CW'(1);
                end
                rsp_d = mk_rsp(nrt_pkg::STS_OK, rd_idx_q, rd_entry, total_d);
              end
              default: begin
                rsp_d = mk_rsp(nrt_pkg::STS_OK, rd_idx_q, rd_entry, total_q);
              end
            endcase
          end else begin
            if (req_q.op == nrt_pkg::OP_NTH && scan_v) begin
              nth_cnt_d = nth_cnt_q + CW'(1);
            end
            if (req_q.op == nrt_pkg::OP_ADD && !scan_v && !free_hit_q) begin
              free_hit_d = 1'b1;
              free_idx_d = rd_idx_q;
            end
            if (rd_idx_q == LAST_C) begin
              state_d = nrt_pkg::FSM_IDLE;
              done_d  = 1'b1;
              if (req_q.op == nrt_pkg::OP_ADD) begin
                if (free_ok) begin
                  upd.long_addr  = req_q.long_addr;
                  upd.short_addr = req_q.short_addr;
                  upd.state      = nrt_pkg::NODE_STATE_NEW;
                  upd.join_at    = now_q;
                  upd.seen_at    = now_q;
                  mem_we         = 1'b1;
                  mem_waddr      = free_slot;
                  mem_wdata      = upd;
                  valid_d[free_slot] = 1'b1;
                  total_d        = total_q + CW'(1);
                  rsp_d          = mk_rsp(nrt_pkg::STS_OK, free_slot, upd, total_d);
                end else begin
                  rsp_d = mk_empty(nrt_pkg::STS_FULL, total_q);
                end
              end else begin
                rsp_d = mk_empty(nrt_pkg::STS_NOT_FOUND, total_q);
              end
            end
          end
        end
      end

      nrt_pkg::FSM_SLOT: begin
        upd.state = req_q.new_state;
        mem_we    = 1'b1;
        mem_wdata = upd;
        rsp_d     = mk_rsp(nrt_pkg::STS_OK, rd_idx_q, upd, total_q);
        done_d    = 1'b1;
        state_d   = nrt_pkg::FSM_IDLE;
      end

      default: begin
        state_d = nrt_pkg::FSM_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/nrt_checker.sv =====
// ----------------------------------------------------------------------------
// nrt_checker
// Port-level checks on the node registry table, bound to the top level.
// ----------------------------------------------------------------------------
module nrt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input nrt_pkg::req_t req_i,
  input logic          done_o,
  input nrt_pkg::rsp_t rsp_o
);

  // a result never shows while a command is still in work
  a_no_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(done_o && busy))
    else $error("result strobe while busy");

  // a transfer either answers next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("transfer neither answered nor in work");

  // busy only rises after a transfer
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without a transfer");

  // a tick is answered in the next cycle
  a_tick_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.op == nrt_pkg::OP_TICK) |=> done_o)
    else $error("tick not answered next cycle");

  // failure results carry no entry
  a_empty_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == nrt_pkg::STS_FULL ||
                rsp_o.status == nrt_pkg::STS_NOT_FOUND ||
                rsp_o.status == nrt_pkg::STS_BAD_SLOT))
    |-> (rsp_o.slot_out == 5'd0 && rsp_o.found_long == 64'd0))
    else $error("failure result carries entry data");

endmodule

bind node_registry_table nrt_checker u_nrt_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

// ===== tb/tb_node_registry_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_node_registry_table
// Self-checking bench for the node registry table. A directed table covers
// the empty table, the extremes and the error codes, then random traffic in
// fill, mixed and drain phases runs the table to full and back. Every
// accepted command updates a shadow copy of the table that predicts its
// result, and each strobed result is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_node_registry_table;

  localparam int SLOTS = 32;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int RND_PHASES = 7;
  localparam int PHASE_ITEMS = 100;
  localparam int LONG_POOL_SZ = 48;
  localparam int SHORT_POOL_SZ = 16;
  localparam int DIR_ROWS = 23;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    nrt_pkg::req_t r;
    bit            typed;
    nrt_pkg::rsp_t e;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  nrt_pkg::req_t req_drv = '0;
  logic done_o;
  nrt_pkg::rsp_t rsp_o;

  // typed expectation travels with the command it belongs to
  bit            typed_drv = 1'b0;
  nrt_pkg::rsp_t typed_rsp = '0;
  bit            no_idle = 1'b0;

  // shadow copy of the table
  logic [63:0] sh_long [SLOTS];
  logic [15:0] sh_short[SLOTS];
  logic [2:0]  sh_state[SLOTS];
  logic [31:0] sh_join [SLOTS];
  logic [31:0] sh_seen [SLOTS];
  bit          sh_valid[SLOTS];
  logic [5:0]  sh_total;
  logic [31:0] sh_now;

  nrt_pkg::rsp_t pending_rsp_q[$];
  nrt_pkg::rsp_t want_rsp;
  nrt_pkg::rsp_t pred_rsp;
  int            mismatch_cnt = 0;

  dir_row_t    dir_tab[DIR_ROWS];
  logic [63:0] long_pool[LONG_POOL_SZ];
  logic [15:0] short_pool[SHORT_POOL_SZ];
  int unsigned op_cut[3][8];
  int          phase_mode[RND_PHASES];

  node_registry_table #(
    .TABLE_SLOTS(SLOTS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_drv),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #(2_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic nrt_pkg::req_t mk_req(logic [2:0] op, logic [63:0] la,
                                           logic [15:0] sa, logic [4:0] sel,
                                           logic [2:0] ns, logic [4:0] nth);
    nrt_pkg::req_t r;
    r.op         = nrt_pkg::op_e'(op);
    r.long_addr  = la;
    r.short_addr = sa;
    r.slot_sel   = sel;
    r.new_state  = ns;
    r.nth_index  = nth;
    return r;
  endfunction

  function automatic nrt_pkg::rsp_t mk_rsp(nrt_pkg::status_e st, logic [4:0] slot,
                                           logic [63:0] la, logic [15:0] sa,
                                           logic [2:0] state, logic [31:0] joined,
                                           logic [31:0] seen, logic [5:0] live);
    nrt_pkg::rsp_t e;
    e.status      = st;
    e.slot_out    = slot;
    e.found_long  = la;
    e.found_short = sa;
    e.found_state = state;
    e.joined_at   = joined;
    e.seen_at     = seen;
    e.live_count  = live;
    return e;
  endfunction

  function automatic int scan_long(logic [63:0] key);
    for (int i = 0; i < SLOTS; i++)
      if (sh_valid[i] && sh_long[i] == key) return i;
    return -1;
  endfunction

  function automatic nrt_pkg::rsp_t entry_rsp(int s);
    nrt_pkg::rsp_t e;
    e             = '0;
    e.slot_out    = 5'(s);
    e.found_long  = sh_long[s];
    e.found_short = sh_short[s];
    e.found_state = sh_state[s];
    e.joined_at   = sh_join[s];
    e.seen_at     = sh_seen[s];
    return e;
  endfunction

  // applies one command to the shadow table and returns its result
  function automatic nrt_pkg::rsp_t predict_registry_rsp(nrt_pkg::req_t r);
    nrt_pkg::rsp_t p;
    int            s;
    int            cnt;
    p = '0;
    s = -1;
    case (r.op)
      nrt_pkg::OP_ADD: begin
        s = scan_long(r.long_addr);
        if (s >= 0) begin
          sh_short[s] = r.short_addr;
          sh_seen[s]  = sh_now;
          p = entry_rsp(s);
          p.status = nrt_pkg::STS_UPDATED;
        end else begin
          for (int i = 0; i < SLOTS; i++)
            if (!sh_valid[i] && s < 0) s = i;
          if (s < 0) begin
            p.status = nrt_pkg::STS_FULL;
          end else begin
            sh_long[s]  = r.long_addr;
            sh_short[s] = r.short_addr;
            sh_state[s] = nrt_pkg::NODE_STATE_NEW;
            sh_join[s]  = sh_now;
            sh_seen[s]  = sh_now;
            sh_valid[s] = 1'b1;
            sh_total    = sh_total + 6'd1;
            p = entry_rsp(s);
          end
        end
      end
      nrt_pkg::OP_FIND_LONG, nrt_pkg::OP_FIND_SHORT: begin
        if (r.op == nrt_pkg::OP_FIND_LONG) begin
          s = scan_long(r.long_addr);
        end else begin
          for (int i = SLOTS - 1; i >= 0; i--)
            if (sh_valid[i] && sh_short[i] == r.short_addr) s = i;
        end
        if (s < 0) p.status = nrt_pkg::STS_NOT_FOUND;
        else p = entry_rsp(s);
      end
      nrt_pkg::OP_REMOVE: begin
        s = scan_long(r.long_addr);
        if (s < 0) begin
          p.status = nrt_pkg::STS_NOT_FOUND;
        end else begin
          p = entry_rsp(s);
          sh_valid[s] = 1'b0;
          if (sh_total != 0) sh_total = sh_total - 6'd1;
        end
      end
      nrt_pkg::OP_SET_STATE: begin
        if (int'(r.slot_sel) >= SLOTS || !sh_valid[r.slot_sel]) begin
          p.status = nrt_pkg::STS_BAD_SLOT;
        end else begin
          sh_state[r.slot_sel] = r.new_state;
          p = entry_rsp(int'(r.slot_sel));
        end
      end
      nrt_pkg::OP_NTH: begin
        cnt = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (sh_valid[i] && s < 0) begin
            if (cnt == int'(r.nth_index)) s = i;
            cnt++;
          end
        end
        if (s < 0) p.status = nrt_pkg::STS_NOT_FOUND;
        else p = entry_rsp(s);
      end
      nrt_pkg::OP_TICK: sh_now = sh_now + 32'd1;
      default: ;
    endcase
    p.live_count = sh_total;
    return p;
  endfunction

  task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, fname, want, got);
    end
  endtask

  // result check first, then record the command transferring at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (pending_rsp_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: result with nothing expected: %p", $realtime, rsp_o);
        end else begin
          want_rsp = pending_rsp_q.pop_front();
          check_field("status", 64'(want_rsp.status), 64'(rsp_o.status));
          check_field("slot_out", 64'(want_rsp.slot_out), 64'(rsp_o.slot_out));
          check_field("found_long", want_rsp.found_long, rsp_o.found_long);
          check_field("found_short", 64'(want_rsp.found_short), 64'(rsp_o.found_short));
          check_field("found_state", 64'(want_rsp.found_state), 64'(rsp_o.found_state));
          check_field("joined_at", 64'(want_rsp.joined_at), 64'(rsp_o.joined_at));
          check_field("seen_at", 64'(want_rsp.seen_at), 64'(rsp_o.seen_at));
          check_field("live_count", 64'(want_rsp.live_count), 64'(rsp_o.live_count));
        end
      end
      if (start && !busy) begin
        pred_rsp = predict_registry_rsp(req_drv);
        pending_rsp_q.push_back(typed_drv ? typed_rsp : pred_rsp);
      end
    end
  end

  // returns right after the edge at which the command transferred
  task automatic send_req(nrt_pkg::req_t r, bit typed, nrt_pkg::rsp_t e);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_drv   <= r;
    typed_drv <= typed;
    typed_rsp <= e;
    start     <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_rsp_q.size() != 0);
  endtask

  initial begin
    nrt_pkg::req_t r;
    int unsigned   roll;
    int            op_idx;
    logic [63:0]   ones;

    ones = '1;
    for (int i = 0; i < SLOTS; i++) sh_valid[i] = 1'b0;
    sh_total = '0;
    sh_now   = '0;

    // empty table, extremes and error codes: expectations typed in
    dir_tab[0]  = '{mk_req(nrt_pkg::OP_FIND_LONG, 64'h0, 16'h0, 5'd0, 3'd0, 5'd0), 1'b1,
                    mk_rsp(nrt_pkg::STS_NOT_FOUND, 5'd0, 64'h0, 16'h0, 3'd0,
                           32'd0, 32'd0, 6'd0)};
    dir_tab[1]  = '{mk_req(nrt_pkg::OP_FIND_SHORT, 64'h0, 16'hFFFF, 5'd0, 3'd0, 5'd0), 1'b1,
                    mk_rsp(nrt_pkg::STS_NOT_FOUND, 5'd0, 64'h0, 16'h0, 3'd0,
                           32'd0, 32'd0, 6'd0)};
    dir_tab[2]  = '{mk_req(nrt_pkg::OP_REMOVE, ones, 16'h0, 5'd0, 3'd0, 5'd0), 1'b1,
                    mk_rsp(nrt_pkg::STS_NOT_FOUND, 5'd0, 64'h0, 16'h0, 3'd0,
                           32'd0, 32'd0, 6'd0)};
    dir_tab[3]  = '{mk_req(nrt_pkg::OP_SET_STATE, 64'h0, 16'h0, 5'd31, 3'd2, 5'd0), 1'b1,
                    mk_rsp(nrt_pkg::STS_BAD_SLOT, 5'd0, 64'h0, 16'h0, 3'd0,
                           32'd0, 32'd0, 6'd0)};
    dir_tab[4]  = '{mk_req(nrt_pkg::OP_NTH, 64'h0, 16'h0, 5'd0, 3'd0, 5'd0), 1'b1,
                    mk_rsp(nrt_pkg::STS_NOT_FOUND, 5'd0, 64'h0, 16'h0, 3'd0,
                           32'd0, 32'd0, 6'd0)};
    dir_tab[5]  = '{mk_req(nrt_pkg::OP_TICK, 64'h0, 16'h0, 5'd0, 3'd0, 5'd0), 1'b1,
                    mk_rsp(nrt_pkg::STS_OK, 5'd0, 64'h0, 16'h0, 3'd0,
                           32'd0, 32'd0, 6'd0)};
    dir_tab[6]  = '{mk_req(OP_UNUSED, ones, 16'hFFFF, 5'd31, 3'd7, 5'd31), 1'b1,
                    mk_rsp(nrt_pkg::STS_OK, 5'd0, 64'h0, 16'h0, 3'd0,
                           32'd0, 32'd0, 6'd0)};
    dir_tab[7]  = '{mk_req(nrt_pkg::OP_ADD, 64'h0, 16'h0, 5'd0, 3'd0, 5'd0), 1'b1,
                    mk_rsp(nrt_pkg::STS_OK, 5'd0, 64'h0, 16'h0, nrt_pkg::NODE_STATE_NEW,
                           32'd1, 32'd1, 6'd1)};
    dir_tab[8]  = '{mk_req(nrt_pkg::OP_ADD, ones, 16'hFFFF, 5'd31, 3'd7, 5'd31), 1'b1,
                    mk_rsp(nrt_pkg::STS_OK, 5'd1, ones, 16'hFFFF, nrt_pkg::NODE_STATE_NEW,
                           32'd1, 32'd1, 6'd2)};
    // from here on the shadow table decides
    dir_tab[9]  = '{mk_req(nrt_pkg::OP_TICK, 64'h5, 16'h5, 5'd5, 3'd5, 5'd5), 1'b0, '0};
    dir_tab[10] = '{mk_req(nrt_pkg::OP_ADD, 64'h0, 16'h1234, 5'd3, 3'd1, 5'd2), 1'b0, '0};
    dir_tab[11] = '{mk_req(nrt_pkg::OP_FIND_LONG, ones, 16'h0, 5'd0, 3'd0, 5'd0), 1'b0, '0};
    dir_tab[12] = '{mk_req(nrt_pkg::OP_FIND_SHORT, 64'h77, 16'h1234, 5'd0, 3'd0, 5'd0),
                    1'b0, '0};
    dir_tab[13] = '{mk_req(nrt_pkg::OP_SET_STATE, 64'h0, 16'h0, 5'd1, 3'd7, 5'd0), 1'b0, '0};
    dir_tab[14] = '{mk_req(nrt_pkg::OP_SET_STATE, 64'h0, 16'h0, 5'd0, 3'd4, 5'd0), 1'b0, '0};
    dir_tab[15] = '{mk_req(nrt_pkg::OP_NTH, 64'h0, 16'h0, 5'd0, 3'd0, 5'd1), 1'b0, '0};
    dir_tab[16] = '{mk_req(nrt_pkg::OP_NTH, 64'h0, 16'h0, 5'd0, 3'd0, 5'd31), 1'b0, '0};
    dir_tab[17] = '{mk_req(nrt_pkg::OP_REMOVE, 64'h0, 16'h0, 5'd0, 3'd0, 5'd0), 1'b0, '0};
    dir_tab[18] = '{mk_req(nrt_pkg::OP_FIND_LONG, 64'h0, 16'h0, 5'd0, 3'd0, 5'd0), 1'b0, '0};
    dir_tab[19] = '{mk_req(nrt_pkg::OP_ADD, 64'hA5A5_5A5A_C3C3_3C3C, 16'h8001,
                           5'd0, 3'd0, 5'd0), 1'b0, '0};
    dir_tab[20] = '{mk_req(nrt_pkg::OP_SET_STATE, 64'h0, 16'h0, 5'd5, 3'd2, 5'd0), 1'b0, '0};
    dir_tab[21] = '{mk_req(nrt_pkg::OP_NTH, 64'h0, 16'h0, 5'd0, 3'd0, 5'd0), 1'b0, '0};
    dir_tab[22] = '{mk_req(nrt_pkg::OP_REMOVE, ones, 16'h0, 5'd0, 3'd0, 5'd0), 1'b0, '0};

    // cumulative op weights out of 100, ordered by op code; fill, mixed, drain
    op_cut[0] = '{65, 72, 78, 80, 86, 92, 98, 100};
    op_cut[1] = '{30, 45, 55, 70, 80, 90, 97, 100};
    op_cut[2] = '{10, 20, 27, 70, 80, 90, 97, 100};
    phase_mode = '{0, 1, 2, 0, 1, 0, 2};

    // pool larger than the table so fill phases reach the full case
    for (int i = 0; i < LONG_POOL_SZ; i++) long_pool[i] = {$urandom, $urandom};
    long_pool[0] = '0;
    long_pool[1] = '1;
    for (int i = 0; i < SHORT_POOL_SZ; i++) short_pool[i] = 16'($urandom);
    short_pool[0] = 16'h0000;
    short_pool[1] = 16'hFFFF;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) send_req(dir_tab[i].r, dir_tab[i].typed, dir_tab[i].e);
    wait_drained();

    for (int ph = 0; ph < RND_PHASES; ph++) begin
      no_idle = (ph == 2 || ph == 5);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        roll   = $urandom_range(0, 99);
        op_idx = 0;
        while (roll >= op_cut[phase_mode[ph]][op_idx]) op_idx++;
        r.op         = nrt_pkg::op_e'(3'(op_idx));
        r.long_addr  = ($urandom_range(0, 99) < 85) ?
                       long_pool[$urandom_range(0, LONG_POOL_SZ - 1)] : {$urandom, $urandom};
        r.short_addr = ($urandom_range(0, 99) < 70) ?
                       short_pool[$urandom_range(0, SHORT_POOL_SZ - 1)] : 16'($urandom);
        r.slot_sel   = 5'($urandom);
        r.new_state  = 3'($urandom);
        r.nth_index  = ($urandom_range(0, 99) < 60) ? 5'($urandom_range(0, 7)) : 5'($urandom);
        send_req(r, 1'b0, '0);
      end
      // sender holds off until the table has answered everything
      wait_drained();
    end

    repeat (SLOTS + 8) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_rsp_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
